// ----- rtl/core/ple4d_pkg.sv -----
// shared types and constants for the 4-d path length block
// no dependencies
package ple4d_pkg;

    localparam int COORD_W    = 16;
    localparam int DIMENSIONS = 4;
    localparam int DIM_IDX_W  = $clog2(DIMENSIONS);
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SUM_W      = SQ_W + $clog2(DIMENSIONS);
    localparam int ROOT_ITERS = (SUM_W + 1) / 2;
    localparam int RW         = 2 * ROOT_ITERS + 1;
    localparam int DIST_W     = ROOT_ITERS + 1;
    localparam int STEP_W     = 18;
    localparam int TOTAL_W    = 40;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic                      start_path;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic signed [COORD_W-1:0] coord_k;
    } t_point_in;

    typedef struct packed {
        logic [STEP_W-1:0]  step_distance;
        logic [TOTAL_W-1:0] path_total;
        logic               total_saturated;
    } t_result;

    typedef enum logic [1:0] {
        KIND_STEP  = 2'd0,
        KIND_START = 2'd1,
        KIND_FIRST = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                             kind;
        logic [DIMENSIONS-1:0][COORD_W-1:0] mag;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// ----- rtl/core/ple4d_front.sv -----
// front end: accepts points, classifies them and forms coordinate difference magnitudes
// depends on ple4d_pkg
module ple4d_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  ple4d_pkg::t_point_in  i_point,
    input  ple4d_pkg::t_fifo_stat i_stat,
    output logic                  o_push,
    output ple4d_pkg::t_work      o_work
);

    logic signed [ple4d_pkg::COORD_W-1:0] r_prev [ple4d_pkg::DIMENSIONS];
    logic                                 r_have_prev;
    logic signed [ple4d_pkg::COORD_W-1:0] w_pt   [ple4d_pkg::DIMENSIONS];
    logic signed [ple4d_pkg::COORD_W:0]   w_diff [ple4d_pkg::DIMENSIONS];

    assign w_pt[0] = i_point.coord_x;
    assign w_pt[1] = i_point.coord_y;
    assign w_pt[2] = i_point.coord_z;
    assign w_pt[3] = i_point.coord_k;

    assign o_ready = !i_stat.full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        for (int d = 0; d < ple4d_pkg::DIMENSIONS; d++) begin
            w_diff[d] = {w_pt[d][ple4d_pkg::COORD_W-1], w_pt[d]}
                      - {r_prev[d][ple4d_pkg::COORD_W-1], r_prev[d]};
            if (w_diff[d] < 0) begin
                o_work.mag[d] = ple4d_pkg::COORD_W'(-w_diff[d]);
            end else begin
                o_work.mag[d] = ple4d_pkg::COORD_W'(w_diff[d]);
            end
        end
        if (i_point.start_path) begin
            o_work.kind = ple4d_pkg::KIND_START;
        end else if (!r_have_prev) begin
            o_work.kind = ple4d_pkg::KIND_FIRST;
        end else begin
            o_work.kind = ple4d_pkg::KIND_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (o_push) begin
            r_have_prev <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_prev <= w_pt;
        end
    end

endmodule

// ----- rtl/core/ple4d_fifo.sv -----
// work queue between front and back ends
// depends on ple4d_pkg
module ple4d_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ple4d_pkg::t_work      i_work,
    input  logic                  i_pop,
    output ple4d_pkg::t_work      o_work,
    output ple4d_pkg::t_fifo_stat o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ple4d_pkg::t_work  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_count;

    assign o_work       = r_mem[r_rptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_work;
        end
    end

endmodule

// ----- rtl/core/ple4d_back.sv -----
// back end: sum of squares, bit-pair ceiling square root, saturating path total
// depends on ple4d_pkg
module ple4d_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ple4d_pkg::t_fifo_stat i_stat,
    input  ple4d_pkg::t_work      i_work,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ple4d_pkg::t_result    o_result
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SQUARE = 4'b0010,
        ST_ROOT   = 4'b0100,
        ST_ACCUM  = 4'b1000
    } t_back_state;

    t_back_state                                  r_state;
    ple4d_pkg::t_kind                             r_kind;
    logic [ple4d_pkg::DIMENSIONS-1:0][ple4d_pkg::COORD_W-1:0] r_mag;
    logic [ple4d_pkg::DIM_IDX_W-1:0]              r_dim;
    logic [ple4d_pkg::SUM_W-1:0]                  r_sum;
    logic [ple4d_pkg::RW-1:0]                     r_rem;
    logic [ple4d_pkg::RW-1:0]                     r_root;
    logic [ple4d_pkg::RW-1:0]                     r_bit;
    logic [ple4d_pkg::TOTAL_W-1:0]                r_total;
    logic                                         r_sat;
    logic                                         r_out_valid;
    ple4d_pkg::t_result                           r_out;

    logic [ple4d_pkg::SQ_W-1:0]      w_sq;
    logic [ple4d_pkg::SUM_W-1:0]     n_sum;
    logic [ple4d_pkg::RW-1:0]        w_trial;
    logic [ple4d_pkg::DIST_W-1:0]    w_dist;
    logic [ple4d_pkg::TOTAL_W:0]     w_add;
    logic [ple4d_pkg::TOTAL_W-1:0]   n_total;
    logic                            n_sat;
    logic                            w_load;

    assign o_pop    = r_state[0] && !i_stat.empty;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign w_sq    = r_mag[r_dim] * r_mag[r_dim];
    assign n_sum   = r_sum + ple4d_pkg::SUM_W'(w_sq);
    assign w_trial = r_root + r_bit;
    assign w_load  = (r_state == ST_ACCUM) && (!r_out_valid || i_ready);

    always_comb begin
        if (r_kind == ple4d_pkg::KIND_STEP) begin
            w_dist = ple4d_pkg::DIST_W'(r_root) + ple4d_pkg::DIST_W'(r_rem != '0);
        end else begin
            w_dist = '0;
        end
        w_add   = {1'b0, r_total} + (ple4d_pkg::TOTAL_W + 1)'(w_dist);
        n_total = r_total;
        n_sat   = r_sat;
        case (r_kind)
            ple4d_pkg::KIND_START: begin
                n_total = '0;
                n_sat   = 1'b0;
            end
            ple4d_pkg::KIND_STEP: begin
                if (w_add >= {1'b0, ple4d_pkg::TOTAL_MAX}) begin
                    n_total = ple4d_pkg::TOTAL_MAX;
                    n_sat   = 1'b1;
                end else begin
                    n_total = w_add[ple4d_pkg::TOTAL_W-1:0];
                end
            end
            default: begin
                n_total = r_total;
                n_sat   = r_sat;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_total     <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_state <= (i_work.kind == ple4d_pkg::KIND_STEP) ? ST_SQUARE : ST_ACCUM;
                    end
                end
                ST_SQUARE: begin
                    if (r_dim == ple4d_pkg::DIM_IDX_W'(ple4d_pkg::DIMENSIONS - 1)) begin
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (r_bit[0]) begin
                        r_state <= ST_ACCUM;
                    end
                end
                ST_ACCUM: begin
                    if (w_load) begin
                        r_total <= n_total;
                        r_sat   <= n_sat;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_kind <= i_work.kind;
                r_mag  <= i_work.mag;
                r_dim  <= '0;
                r_sum  <= '0;
            end
            ST_SQUARE: begin
                r_sum  <= n_sum;
                r_dim  <= r_dim + 1'b1;
                r_rem  <= ple4d_pkg::RW'(n_sum);
                r_root <= '0;
                r_bit  <= ple4d_pkg::RW'(1) << (2 * (ple4d_pkg::ROOT_ITERS - 1));
            end
            ST_ROOT: begin
                if (r_rem >= w_trial) begin
                    r_rem  <= r_rem - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ST_ACCUM: begin
                if (w_load) begin
                    r_out.step_distance   <= ple4d_pkg::STEP_W'(w_dist);
                    r_out.path_total      <= n_total;
                    r_out.total_saturated <= n_sat;
                end
            end
            default: begin
                r_dim <= '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/path_length_4d_euclidean_top.sv -----
// a point that needs a distance passes the queue, then the back end square, root and accumulate states
// the back end pops a new point only from its idle state, after the 17-step bit-pair square root
// path starts and first points skip the square and root states; the queue holds QUEUE_DEPTH points
// reset: i_rst_n low at a clock edge empties the queue, drops any pending result,
// clears the path total, the saturation flag and the previous-point flag
module path_length_4d_euclidean_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ple4d_pkg::t_point_in i_point,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ple4d_pkg::t_result   o_result
);

    ple4d_pkg::t_fifo_stat w_stat;
    ple4d_pkg::t_work      w_push_work;
    ple4d_pkg::t_work      w_pop_work;
    logic                  w_push;
    logic                  w_pop;

    ple4d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_point (i_point),
        .i_stat  (w_stat),
        .o_push  (w_push),
        .o_work  (w_push_work)
    );

    ple4d_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_work  (w_push_work),
        .i_pop   (w_pop),
        .o_work  (w_pop_work),
        .o_stat  (w_stat)
    );

    ple4d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stat   (w_stat),
        .i_work   (w_pop_work),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    a_sat_means_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.total_saturated |-> o_result.path_total == ple4d_pkg::TOTAL_MAX)
        else $error("saturated result without maximum total");

    a_max_means_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.total_saturated |-> o_result.path_total != ple4d_pkg::TOTAL_MAX)
        else $error("maximum total without saturation flag");

    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.full && w_stat.empty) && !(w_pop && w_stat.empty))
        else $error("queue status inconsistent");

    a_start_zero_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.path_total == '0 |-> o_result.step_distance == '0)
        else $error("nonzero step with empty total");

endmodule

// ----- tb/sv/path_length_checker.sv -----
// checker for the 4-d path length block: predicts each result and compares it
// depends on ple4d_pkg; instantiated beside the block by tb_top
module path_length_checker
    import ple4d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_pt_valid,
    input  logic      i_pt_ready,
    input  t_point_in i_point,
    input  logic      i_res_valid,
    input  logic      i_res_ready,
    input  t_result   i_result,
    output int        o_fail_count,
    output int        o_pending
);

    t_result                   expected_results[$];
    logic signed [COORD_W-1:0] last_point [DIMENSIONS];
    logic                      have_last;
    logic [TOTAL_W-1:0]        path_sum;
    logic                      sum_stuck;
    int                        fails = 0;

    // smallest r with r*r >= n
    function automatic longint unsigned ceil_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned cand;
        int b;
        r = 0;
        for (b = 18; b >= 0; b--) begin
            cand = r | (longint'(1) << b);
            if (cand * cand <= n)
                r = cand;
        end
        if (r * r < n)
            r++;
        return r;
    endfunction

    function automatic t_result predict_step(input t_point_in p);
        logic signed [COORD_W-1:0] cur [DIMENSIONS];
        longint          d;
        longint unsigned sq_sum;
        longint unsigned step_len;
        longint unsigned widened;
        t_result         r;
        int              i;
        cur[0] = p.coord_x;
        cur[1] = p.coord_y;
        cur[2] = p.coord_z;
        cur[3] = p.coord_k;
        step_len = 0;
        if (p.start_path) begin
            path_sum  = '0;
            sum_stuck = 1'b0;
        end else if (have_last) begin
            sq_sum = 0;
            for (i = 0; i < DIMENSIONS; i++) begin
                d = longint'(cur[i]) - longint'(last_point[i]);
                sq_sum += longint'(d * d);
            end
            step_len = ceil_root(sq_sum);
            widened  = longint'(path_sum) + step_len;
            if (widened >= longint'(TOTAL_MAX)) begin
                path_sum  = TOTAL_MAX;
                sum_stuck = 1'b1;
            end else begin
                path_sum = widened[TOTAL_W-1:0];
            end
        end
        for (i = 0; i < DIMENSIONS; i++)
            last_point[i] = cur[i];
        have_last = 1'b1;
        r.step_distance   = step_len[STEP_W-1:0];
        r.path_total      = path_sum;
        r.total_saturated = sum_stuck;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < DIMENSIONS; i++)
                last_point[i] = '0;
            have_last = 1'b0;
            path_sum  = '0;
            sum_stuck = 1'b0;
            expected_results.delete();
        end else begin
            if (i_pt_valid && i_pt_ready)
                expected_results.push_back(predict_step(i_point));
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result transfer, expected none, got %p",
                             $time, i_result);
                end else begin
                    want = expected_results.pop_front();
                    if (i_result.step_distance !== want.step_distance) begin
                        fails++;
                        $display("%0t: step_distance expected %0d got %0d",
                                 $time, want.step_distance, i_result.step_distance);
                    end
                    if (i_result.path_total !== want.path_total) begin
                        fails++;
                        $display("%0t: path_total expected %0d got %0d",
                                 $time, want.path_total, i_result.path_total);
                    end
                    if (i_result.total_saturated !== want.total_saturated) begin
                        fails++;
                        $display("%0t: total_saturated expected %0b got %0b",
                                 $time, want.total_saturated, i_result.total_saturated);
                    end
                end
            end
        end
        o_pending    = expected_results.size();
        o_fail_count = fails;
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// top of the path length testbench: clock, reset, point stimulus and result stalls
// depends on ple4d_pkg, path_length_4d_euclidean_top and path_length_checker
module tb_top;
    import ple4d_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_ITEMS = 232;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_point_in i_point;
    logic      o_valid;
    logic      i_ready;
    t_result   o_result;

    int fail_count;
    int pending_count;
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    t_point_in last_sent = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    path_length_4d_euclidean_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_point  (i_point),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    path_length_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pt_valid   (i_valid),
        .i_pt_ready   (o_ready),
        .i_point      (i_point),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // result side back-pressure
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic t_point_in make_point(input logic s, input int x, input int y,
                                             input int z, input int k);
        t_point_in p;
        p.start_path = s;
        p.coord_x    = x[COORD_W-1:0];
        p.coord_y    = y[COORD_W-1:0];
        p.coord_z    = z[COORD_W-1:0];
        p.coord_k    = k[COORD_W-1:0];
        return p;
    endfunction

    // full range, small or medium move from the last point, or an extreme
    function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] base);
        logic [COORD_W-1:0] extremes [4];
        extremes = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        case ($urandom_range(0, 3))
            0: return COORD_W'($urandom);
            1: return COORD_W'(base + $urandom_range(0, 16) - 8);
            2: return COORD_W'(base + $urandom_range(0, 2047) - 1024);
            default: return extremes[2'($urandom_range(0, 3))];
        endcase
    endfunction

    task automatic send_point(input t_point_in pt);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_point   = pt;
        last_sent = pt;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid = 1'b0;
        while (pending_count != 0)
            @(negedge i_clk);
    endtask

    initial begin
        t_point_in directed_pts[$];
        t_point_in pt;
        int idle_by_phase [4];
        int stall_by_phase [4];
        idle_by_phase  = '{0, 56, 0, 36};
        stall_by_phase = '{0, 0, 56, 36};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_point = '0;

        // first point after reset has no start flag
        directed_pts.push_back(make_point(0, 100, -200, 300, -400));
        directed_pts.push_back(make_point(0, 100, -200, 300, -400));
        directed_pts.push_back(make_point(0, 101, -199, 300, -400));
        directed_pts.push_back(make_point(0, 104, -195, 300, -400));
        directed_pts.push_back(make_point(1, -32768, -32768, -32768, -32768));
        directed_pts.push_back(make_point(0, 32767, 32767, 32767, 32767));
        directed_pts.push_back(make_point(0, -32768, 32767, -32768, 32767));
        directed_pts.push_back(make_point(0, 32767, -32768, 32767, -32768));
        directed_pts.push_back(make_point(0, 0, 0, 0, 0));
        directed_pts.push_back(make_point(1, 32767, -32768, 0, -1));
        directed_pts.push_back(make_point(0, -1, -1, -1, -1));
        directed_pts.push_back(make_point(0, 0, -1, -1, -1));
        directed_pts.push_back(make_point(0, 1, 0, 0, 0));
        directed_pts.push_back(make_point(0, 1, 0, 0, 3));
        directed_pts.push_back(make_point(0, 32767, 32767, 32767, 32767));
        directed_pts.push_back(make_point(0, -32768, -32768, -32768, -32768));
        directed_pts.push_back(make_point(1, 5, 5, 5, 5));
        directed_pts.push_back(make_point(1, 5, 5, 5, 5));
        directed_pts.push_back(make_point(0, 5, 5, 5, 5));
        directed_pts.push_back(make_point(0, 21845, -21846, 21845, -21846));
        directed_pts.push_back(make_point(0, -21846, 21845, -21846, 21845));

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_pts[n])
            send_point(directed_pts[n]);
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pt.start_path = ($urandom_range(0, 15) == 0);
                pt.coord_x    = pick_coord(last_sent.coord_x);
                pt.coord_y    = pick_coord(last_sent.coord_y);
                pt.coord_z    = pick_coord(last_sent.coord_z);
                pt.coord_k    = pick_coord(last_sent.coord_k);
                send_point(pt);
            end
            drain_results();
        end

        stall_pct = 0;
        repeat (60) @(negedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
